// ===== rtl/ipfl_pkg.sv =====
// Shared types, constants and helper functions for the IPv4 source prefix denylist filter.
package ipfl_pkg;

    // Default number of prefix table slots.
    localparam int TABLE_ENTRIES_DEF = 1024;

    // Depth of the verdict job queue between the parser and the lookup engine.
    localparam int QUEUE_DEPTH = 4;

    // Operation codes of an input request.
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Verdict codes.
    localparam logic VERDICT_PASS = 1'b0;
    localparam logic VERDICT_DROP = 1'b1;

    // Cause codes.
    localparam logic [1:0] CAUSE_LISTED    = 2'd0;
    localparam logic [1:0] CAUSE_NOT_IPV4  = 2'd1;
    localparam logic [1:0] CAUSE_TRUNCATED = 2'd2;
    localparam logic [1:0] CAUSE_UNLISTED  = 2'd3;

    // Widths of one table entry: valid mark, prefix length, prefix address.
    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 6;
    localparam int ENTRY_W = 1 + LEN_W + ADDR_W;

    // Longest legal prefix.
    localparam logic [LEN_W-1:0] LEN_MAX = 6'd32;

    // One table entry as stored in the prefix RAM.
    typedef struct packed {
        logic              valid;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] addr;
    } entry_t;

    // One job handed from the parser to the lookup engine.
    typedef struct packed {
        logic              lookup;
        logic [1:0]        cause;
        logic [ADDR_W-1:0] src;
    } job_t;

    // Status the parser needs before it takes a request.
    typedef struct packed {
        logic q_full;
        logic q_empty;
        logic back_idle;
    } gate_t;

    // Parser states.
    typedef enum logic {
        F_CLEAR,
        F_RUN
    } front_state_t;

    // Lookup engine states.
    typedef enum logic {
        B_IDLE,
        B_SCAN
    } back_state_t;

    // Address width for a table of n slots.
    function automatic int idx_width(input int n);
        idx_width = (n > 1) ? $clog2(n) : 1;
    endfunction

    // Network mask for a prefix length of 0 to 32.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] sh;
        sh = LEN_MAX - len;
        if (len == '0)
        begin
            prefix_mask = '0;
        end
        else
        begin
            prefix_mask = {ADDR_W{1'b1}} << sh;
        end
    endfunction

endpackage

// ===== rtl/ipfl_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module ipfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [ipfl_pkg::idx_width(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [ipfl_pkg::idx_width(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);
    import ipfl_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ipfl_front.sv =====
// Frame byte parser, table write port and post-reset table clearing sweep.
module ipfl_front #(
    parameter int TABLE_ENTRIES = ipfl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic                                          operation,
    input  logic [7:0]                                    data_byte,
    input  logic                                          last_byte,
    input  logic [9:0]                                    entry_slot,
    input  logic [31:0]                                   entry_address,
    input  logic [5:0]                                    entry_prefix_len,
    input  logic                                          entry_valid,
    input  ipfl_pkg::gate_t                               gate,
    output logic                                          push,
    output ipfl_pkg::job_t                                push_job,
    output logic                                          clearing,
    output logic                                          wr_en,
    output logic [ipfl_pkg::idx_width(TABLE_ENTRIES)-1:0] wr_addr,
    output logic [ipfl_pkg::ENTRY_W-1:0]                  wr_data
);
    import ipfl_pkg::*;

    localparam int IDX_W  = idx_width(TABLE_ENTRIES);
    localparam int SLOT_W = 17;

    localparam logic [5:0] COUNT_MAX      = 6'd63;
    localparam logic [5:0] POS_ETH_HI     = 6'd12;
    localparam logic [5:0] POS_ETH_LO     = 6'd13;
    localparam logic [5:0] POS_SRC_FIRST  = 6'd26;
    localparam logic [5:0] POS_SRC_LAST   = 6'd29;
    localparam logic [5:0] ETH_HDR_BYTES  = 6'd14;
    localparam logic [5:0] IPV4_MIN_BYTES = 6'd34;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

    front_state_t     state_reg, state_next;
    logic [IDX_W-1:0] clr_idx_reg, clr_idx_next;
    logic [5:0]       count_reg, count_next;
    logic [15:0]      eth_reg, eth_next;
    logic [31:0]      src_reg, src_next;

    logic              accept;
    logic [5:0]        count_upd;
    logic [15:0]       eth_upd;
    logic [31:0]       src_upd;
    logic [SLOT_W-1:0] slot_ext;
    logic              slot_ok;
    logic [5:0]        len_clamped;
    entry_t            entry;

    // State and frame capture registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_CLEAR;
            clr_idx_reg <= '0;
            count_reg   <= '0;
            eth_reg     <= '0;
            src_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            count_reg   <= count_next;
            eth_reg     <= eth_next;
            src_reg     <= src_next;
        end
    end

    // Next state, byte capture, classification and table writes.
    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        count_next   = count_reg;
        eth_next     = eth_reg;
        src_next     = src_reg;
        in_ready     = 1'b0;
        push         = 1'b0;
        push_job     = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;

        // Byte capture values for the byte now on the input.
        count_upd = (count_reg == COUNT_MAX) ? count_reg : count_reg + 6'd1;
        eth_upd   = eth_reg;
        src_upd   = src_reg;
        if (count_reg == POS_ETH_HI || count_reg == POS_ETH_LO)
        begin
            eth_upd = {eth_reg[7:0], data_byte};
        end
        else if (count_reg >= POS_SRC_FIRST && count_reg <= POS_SRC_LAST)
        begin
            src_upd = {src_reg[23:0], data_byte};
        end

        // Table write decode.
        slot_ext    = SLOT_W'(entry_slot);
        slot_ok     = slot_ext < SLOT_W'(TABLE_ENTRIES);
        len_clamped = (entry_prefix_len > LEN_MAX) ? LEN_MAX : entry_prefix_len;
        entry.valid = entry_valid;
        entry.len   = len_clamped;
        entry.addr  = entry_address;

        case (state_reg)
            F_CLEAR:
            begin
                // Sweep the table once after reset so every valid mark reads zero.
                wr_en        = 1'b1;
                wr_addr      = clr_idx_reg;
                wr_data      = '0;
                clr_idx_next = clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == IDX_W'(TABLE_ENTRIES - 1))
                begin
                    state_next = F_RUN;
                end
            end
            F_RUN:
            begin
                // Table writes wait until every earlier frame has its verdict.
                if (operation == OP_WRITE)
                begin
                    in_ready = gate.q_empty && gate.back_idle;
                end
                else
                begin
                    in_ready = !gate.q_full;
                end
            end
            default:
            begin
                state_next = F_CLEAR;
            end
        endcase

        accept = in_valid && in_ready;

        if (accept && operation == OP_WRITE)
        begin
            wr_en   = slot_ok;
            wr_addr = slot_ext[IDX_W-1:0];
            wr_data = entry;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                // Classify the finished frame and hand the job to the lookup engine.
                push         = 1'b1;
                push_job.src = src_upd;
                if (count_upd < ETH_HDR_BYTES)
                begin
                    push_job.cause = CAUSE_TRUNCATED;
                end
                else if (eth_upd != ETHERTYPE_IPV4)
                begin
                    push_job.cause = CAUSE_NOT_IPV4;
                end
                else if (count_upd < IPV4_MIN_BYTES)
                begin
                    push_job.cause = CAUSE_TRUNCATED;
                end
                else
                begin
                    push_job.lookup = 1'b1;
                    push_job.cause  = CAUSE_UNLISTED;
                end
                count_next = '0;
                eth_next   = '0;
                src_next   = '0;
            end
            else
            begin
                count_next = count_upd;
                eth_next   = eth_upd;
                src_next   = src_upd;
            end
        end
    end

    assign clearing = (state_reg == F_CLEAR);

endmodule

// ===== rtl/ipfl_queue.sv =====
// Short job queue between the frame parser and the lookup engine.
module ipfl_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ipfl_pkg::job_t push_job,
    input  logic           pop,
    output ipfl_pkg::job_t head,
    output logic           full,
    output logic           empty
);
    import ipfl_pkg::*;

    localparam int PTR_W = idx_width(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

endmodule

// ===== rtl/ipfl_back.sv =====
// Lookup engine: scans the prefix table for a job and holds the verdict for the receiver.
module ipfl_back #(
    parameter int TABLE_ENTRIES = ipfl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  ipfl_pkg::job_t                                head,
    input  logic                                          q_empty,
    output logic                                          pop,
    output logic                                          back_idle,
    output logic                                          rd_en,
    output logic [ipfl_pkg::idx_width(TABLE_ENTRIES)-1:0] rd_addr,
    input  logic [ipfl_pkg::ENTRY_W-1:0]                  rd_data,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic                                          verdict,
    output logic [1:0]                                    cause
);
    import ipfl_pkg::*;

    localparam int IDX_W = idx_width(TABLE_ENTRIES);

    back_state_t      state_reg, state_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             issued_all_reg, issued_all_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic             cmp_last_reg, cmp_last_next;
    logic [31:0]      src_reg, src_next;
    logic             out_valid_reg, out_valid_next;
    logic             verdict_reg, verdict_next;
    logic [1:0]       cause_reg, cause_next;

    entry_t           entry;
    logic             hit;
    logic             out_free;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            issued_all_reg <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issued_all_reg <= issued_all_next;
            cmp_vld_reg    <= cmp_vld_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        cmp_last_reg <= cmp_last_next;
        src_reg      <= src_next;
        verdict_reg  <= verdict_next;
        cause_reg    <= cause_next;
    end

    // Match of the entry read in the previous cycle.
    assign entry = entry_t'(rd_data);
    assign hit   = entry.valid && (((src_reg ^ entry.addr) & prefix_mask(entry.len)) == '0);

    // Next state, table scan and output register.
    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        issued_all_next = issued_all_reg;
        cmp_vld_next    = 1'b0;
        cmp_last_next   = cmp_last_reg;
        src_next        = src_reg;
        verdict_next    = verdict_reg;
        cause_next      = cause_reg;
        pop             = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = scan_idx_reg;

        out_free       = !out_valid_reg || out_ready;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            B_IDLE:
            begin
                // Take the next job once the output register can accept a verdict.
                if (!q_empty && out_free)
                begin
                    pop = 1'b1;
                    if (head.lookup)
                    begin
                        src_next        = head.src;
                        scan_idx_next   = '0;
                        issued_all_next = 1'b0;
                        state_next      = B_SCAN;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        verdict_next   = VERDICT_PASS;
                        cause_next     = head.cause;
                    end
                end
            end
            B_SCAN:
            begin
                // Issue one table read per cycle.
                if (!issued_all_reg)
                begin
                    rd_en         = 1'b1;
                    cmp_vld_next  = 1'b1;
                    cmp_last_next = (scan_idx_reg == IDX_W'(TABLE_ENTRIES - 1));
                    if (scan_idx_reg == IDX_W'(TABLE_ENTRIES - 1))
                    begin
                        issued_all_next = 1'b1;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + IDX_W'(1);
                    end
                end
                // Stop at the first match or after the last slot.
                if (cmp_vld_reg && (hit || cmp_last_reg))
                begin
                    out_valid_next = 1'b1;
                    verdict_next   = hit ? VERDICT_DROP : VERDICT_PASS;
                    cause_next     = hit ? CAUSE_LISTED : CAUSE_UNLISTED;
                    cmp_vld_next   = 1'b0;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign back_idle = (state_reg == B_IDLE);
    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;
    assign cause     = cause_reg;

endmodule

// ===== rtl/ipv4_source_prefix_denylist_filter.sv =====
// Top level of the IPv4 source prefix denylist filter.
//
// One input channel (in_valid/in_ready) carries two kinds of request. A table
// write (operation = 1) sets one prefix slot; slots at or beyond TABLE_ENTRIES
// are ignored. A packet byte (operation = 0) carries one Ethernet frame byte
// in wire order, with last_byte on the final byte. Each frame gives exactly
// one verdict/cause request on the output channel (out_valid/out_ready).
// Packet bytes are taken one per cycle while the four-entry job queue has room.
// A verdict that needs no table lookup passes through the job queue to the
// output register; an IPv4 frame is checked by a scan of the prefix RAM, one
// slot per cycle, which ends early at the first matching prefix. Frames queue
// behind one another. A table write is taken only when the queue is empty and
// no scan runs. After reset a clearing pass over all TABLE_ENTRIES slots
// zeroes the table while in_ready stays low. When the receiver stalls, the
// verdict waits in the output register, the queue fills, and then in_ready
// falls.
module ipv4_source_prefix_denylist_filter #(
    parameter int TABLE_ENTRIES = ipfl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [9:0]  entry_slot,
    input  logic [31:0] entry_address,
    input  logic [5:0]  entry_prefix_len,
    input  logic        entry_valid,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        verdict,
    output logic [1:0]  cause
);
    import ipfl_pkg::*;

    localparam int IDX_W = idx_width(TABLE_ENTRIES);

    gate_t              gate;
    logic               push;
    job_t               push_job;
    logic               pop;
    job_t               head;
    logic               q_full;
    logic               q_empty;
    logic               back_idle;
    logic               clearing;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    assign gate.q_full    = q_full;
    assign gate.q_empty   = q_empty;
    assign gate.back_idle = back_idle;

    // Frame parser and table writer.
    ipfl_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .data_byte        (data_byte),
        .last_byte        (last_byte),
        .entry_slot       (entry_slot),
        .entry_address    (entry_address),
        .entry_prefix_len (entry_prefix_len),
        .entry_valid      (entry_valid),
        .gate             (gate),
        .push             (push),
        .push_job         (push_job),
        .clearing         (clearing),
        .wr_en            (wr_en),
        .wr_addr          (wr_addr),
        .wr_data          (wr_data)
    );

    // Job queue.
    ipfl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Prefix table.
    ipfl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Lookup engine and output register.
    ipfl_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .back_idle (back_idle),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .verdict   (verdict),
        .cause     (cause)
    );

`ifndef ASSERT_OFF
    // A table write never overtakes a frame still waiting for its verdict.
    a_write_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && operation == OP_WRITE) |-> (q_empty && back_idle))
        else $error("table write accepted while a verdict is pending");

    // No request is taken during the clearing pass.
    a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !in_ready)
        else $error("request accepted during table clearing");

    // The queue never takes a job while full.
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("job queue overflow");

    // Only a listed source is dropped.
    a_drop_means_listed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((verdict == VERDICT_DROP) == (cause == CAUSE_LISTED)))
        else $error("verdict and cause disagree");
`endif

endmodule

// ===== verif/tb_ipv4_source_prefix_denylist_filter.sv =====
// Self-checking testbench for the IPv4 source prefix denylist filter.
module tb_ipv4_source_prefix_denylist_filter;

    timeunit 1ns;
    timeprecision 1ps;

    import ipfl_pkg::*;

    localparam int TABLE_SIZE     = TABLE_ENTRIES_DEF;
    localparam int ITEM_TARGET    = 1850;
    localparam int LIMIT_CYCLES   = 1_000_000;
    localparam int TAIL_CYCLES    = 2 * TABLE_SIZE + 64;
    localparam int DIRECTED_ROWS  = 26;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam int ETH_HEADER_LEN = 14;
    localparam int IPV4_MIN_LEN   = 34;
    localparam logic [5:0] COUNT_CAP = 6'd63;

    // One input request, one field per port.
    typedef struct packed {
        logic        op;
        logic [7:0]  data;
        logic        last;
        logic [9:0]  slot;
        logic [31:0] addr;
        logic [5:0]  plen;
        logic        valid;
    } filter_req_t;

    // One output request.
    typedef struct packed {
        logic       verdict;
        logic [1:0] cause;
    } frame_outcome_t;

    typedef enum logic {
        ROW_FRAME,
        ROW_WRITE
    } row_kind_t;

    // One line of the directed table: either a whole frame or one slot write.
    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  len;
        logic [15:0] etype;
        logic [31:0] src;
        logic [9:0]  slot;
        logic [31:0] addr;
        logic [5:0]  plen;
        logic        valid;
        logic        typed;
        logic        verdict;
        logic [1:0]  cause;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        operation = OP_BYTE;
    logic [7:0]  data_byte = '0;
    logic        last_byte = 1'b0;
    logic [9:0]  entry_slot = '0;
    logic [31:0] entry_address = '0;
    logic [5:0]  entry_prefix_len = '0;
    logic        entry_valid = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        verdict;
    logic [1:0]  cause;

    // Shadow copy of the prefix table and of the frame parser.
    logic [31:0] deny_addr [TABLE_SIZE];
    logic [5:0]  deny_len [TABLE_SIZE];
    bit          deny_valid [TABLE_SIZE];
    logic [5:0]  parse_count = '0;
    logic [15:0] parse_ethertype = '0;
    logic [31:0] parse_source = '0;

    frame_outcome_t pending_verdicts [$];
    directed_row_t  directed_rows [DIRECTED_ROWS];

    int error_count = 0;
    int cycle_count = 0;
    int requests_sent = 0;
    int writes_sent = 0;
    int frames_sent = 0;
    int verdicts_expected = 0;
    int cause_seen [4] = '{0, 0, 0, 0};
    int burst_left = 0;
    int rx_mode = 0;
    int rx_phase_left = 0;
    int rx_hold = 0;

    ipv4_source_prefix_denylist_filter #(
        .TABLE_ENTRIES(TABLE_SIZE)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .data_byte(data_byte),
        .last_byte(last_byte),
        .entry_slot(entry_slot),
        .entry_address(entry_address),
        .entry_prefix_len(entry_prefix_len),
        .entry_valid(entry_valid),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .verdict(verdict),
        .cause(cause)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d verdicts outstanding",
                     cycle_count, pending_verdicts.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Mask of the leading len bits; lengths of 32 and above cover the whole address.
    function automatic logic [31:0] network_mask(input logic [5:0] len);
        if (len == 6'd0)
        begin
            return 32'd0;
        end
        else if (len >= 6'd32)
        begin
            return 32'hFFFF_FFFF;
        end
        return ~(32'hFFFF_FFFF >> len);
    endfunction

    // Applies one accepted request to the shadow state and works out its verdict.
    task automatic update_filter_model(input filter_req_t r, output bit produced,
                                       output frame_outcome_t res);
        logic [5:0] pos;
        bit         listed;
        produced = 1'b0;
        res = '0;
        if (r.op == OP_WRITE)
        begin
            // Slot writes store address and length whatever the valid mark.
            if (int'(r.slot) < TABLE_SIZE)
            begin
                deny_addr[r.slot] = r.addr;
                deny_len[r.slot] = (r.plen > 6'd32) ? 6'd32 : r.plen;
                deny_valid[r.slot] = r.valid;
            end
            return;
        end

        // Capture the EtherType and the source address at their byte offsets.
        pos = parse_count;
        if (pos == 6'd12 || pos == 6'd13)
        begin
            parse_ethertype = {parse_ethertype[7:0], r.data};
        end
        else if (pos >= 6'd26 && pos <= 6'd29)
        begin
            parse_source = {parse_source[23:0], r.data};
        end
        if (parse_count < COUNT_CAP)
        begin
            parse_count = parse_count + 6'd1;
        end
        if (!r.last)
        begin
            return;
        end

        // Verdict order: short frame, other protocol, short IPv4 header, lookup.
        produced = 1'b1;
        if (int'(parse_count) < ETH_HEADER_LEN)
        begin
            res = '{VERDICT_PASS, CAUSE_TRUNCATED};
        end
        else if (parse_ethertype != ETHERTYPE_IPV4)
        begin
            res = '{VERDICT_PASS, CAUSE_NOT_IPV4};
        end
        else if (int'(parse_count) < IPV4_MIN_LEN)
        begin
            res = '{VERDICT_PASS, CAUSE_TRUNCATED};
        end
        else
        begin
            listed = 1'b0;
            for (int k = 0; k < TABLE_SIZE; k++)
            begin
                if (deny_valid[k] &&
                    ((parse_source ^ deny_addr[k]) & network_mask(deny_len[k])) == 32'd0)
                begin
                    listed = 1'b1;
                end
            end
            if (listed)
            begin
                res = '{VERDICT_DROP, CAUSE_LISTED};
            end
            else
            begin
                res = '{VERDICT_PASS, CAUSE_UNLISTED};
            end
        end
        parse_count = '0;
        parse_ethertype = '0;
        parse_source = '0;
    endtask

    // Sends one request in bursts with random gaps, then records its verdict, if any.
    task automatic send_request(input filter_req_t r, input bit typed,
                                input frame_outcome_t typed_res);
        bit             produced;
        frame_outcome_t res;
        int             gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 250)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        operation        <= r.op;
        data_byte        <= r.data;
        last_byte        <= r.last;
        entry_slot       <= r.slot;
        entry_address    <= r.addr;
        entry_prefix_len <= r.plen;
        entry_valid      <= r.valid;
        in_valid         <= 1'b1;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        requests_sent++;
        if (r.op == OP_WRITE)
        begin
            writes_sent++;
        end
        update_filter_model(r, produced, res);
        if (produced)
        begin
            // Typed rows of the directed table carry their own expectation.
            if (typed)
            begin
                res = typed_res;
            end
            pending_verdicts.push_back(res);
            verdicts_expected++;
            frames_sent++;
        end
    endtask

    // Writes a random slot, mostly among a few hot slots so entries get replaced.
    task automatic random_write();
        filter_req_t r;
        int          sel;
        sel = $urandom_range(0, 9);
        r.op = OP_WRITE;
        r.data = 8'($urandom);
        r.last = 1'($urandom_range(0, 1));
        r.addr = $urandom;
        r.valid = ($urandom_range(0, 9) < 7);
        if (sel < 7)
        begin
            r.slot = 10'($urandom_range(0, 7));
            r.plen = 6'($urandom_range(1, 32));
        end
        else
        begin
            r.slot = (sel == 7) ? 10'd1023 : 10'($urandom_range(0, 1023));
            r.plen = 6'($urandom_range(12, 32));
        end
        sel = $urandom_range(0, 19);
        if (sel == 0 && r.slot < 10'd8)
        begin
            r.plen = 6'd0;
        end
        else if (sel < 3)
        begin
            r.plen = 6'($urandom_range(33, 63));
        end
        send_request(r, 1'b0, '0);
    endtask

    // Source address for an IPv4 frame: inside a live prefix, just outside one, all zeros or all ones, or random.
    function automatic logic [31:0] pick_source();
        logic [31:0] m;
        logic [31:0] src;
        int          sel;
        int          s;
        int          c;
        sel = $urandom_range(0, 9);
        src = $urandom;
        s = -1;
        if (sel == 9)
        begin
            src = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
        end
        else if (sel < 7)
        begin
            for (int tries = 0; tries < 16; tries++)
            begin
                c = $urandom_range(0, 7);
                if (s < 0 && deny_valid[c])
                begin
                    s = c;
                end
            end
            if (s >= 0)
            begin
                m = network_mask(deny_len[s]);
                src = (deny_addr[s] & m) | (src & ~m);
                // Near miss: flip one bit inside the prefix.
                if (sel >= 5 && deny_len[s] != 6'd0)
                begin
                    c = 32 - $urandom_range(1, int'(deny_len[s]));
                    src[c] = ~src[c];
                end
            end
        end
        return src;
    endfunction

    // Sends a frame byte by byte, optionally with a slot write slipped in mid-frame.
    task automatic send_frame(input int len, input logic [15:0] etype, input logic [31:0] src,
                              input bit allow_insert, input bit typed,
                              input frame_outcome_t typed_res);
        filter_req_t r;
        int          insert_at;
        insert_at = (allow_insert && $urandom_range(0, 9) == 0) ? $urandom_range(1, len) : -1;
        for (int i = 0; i < len; i++)
        begin
            if (i == insert_at)
            begin
                random_write();
            end
            r.op = OP_BYTE;
            r.data = 8'($urandom);
            r.last = (i == len - 1);
            r.slot = 10'($urandom);
            r.addr = $urandom;
            r.plen = 6'($urandom);
            r.valid = 1'($urandom_range(0, 1));
            case (i)
                12: r.data = etype[15:8];
                13: r.data = etype[7:0];
                26: r.data = src[31:24];
                27: r.data = src[23:16];
                28: r.data = src[15:8];
                29: r.data = src[7:0];
                default: ;
            endcase
            send_request(r, typed, typed_res);
        end
    endtask

    // Stops the sender until every expected verdict has come out.
    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic directed_row_t frame_row(input int len, input logic [15:0] etype,
                                                input logic [31:0] src, input bit typed,
                                                input logic v, input logic [1:0] c);
        return '{ROW_FRAME, 8'(len), etype, src, 10'd0, 32'd0, 6'd0, 1'b0, typed, v, c};
    endfunction

    function automatic directed_row_t write_row(input logic [9:0] slot, input logic [31:0] addr,
                                                input logic [5:0] plen, input logic valid);
        return '{ROW_WRITE, 8'd0, 16'd0, 32'd0, slot, addr, plen, valid, 1'b0, 1'b0, 2'd0};
    endfunction

    // Receiver: phases of always ready, random ready, and long stalls.
    always @(negedge clk)
    begin
        if (rx_phase_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_phase_left = $urandom_range(10, 200);
        end
        rx_phase_left--;
        case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2:
            begin
                if (rx_hold == 0)
                begin
                    out_ready <= 1'b1;
                    if ($urandom_range(0, 3) == 0)
                    begin
                        rx_hold = $urandom_range(1, 12);
                    end
                end
                else
                begin
                    out_ready <= 1'b0;
                    rx_hold--;
                end
            end
            default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Compare each accepted verdict request with the oldest expectation.
    always @(posedge clk)
    begin
        frame_outcome_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                report_mismatch($sformatf("verdict %b cause %b with nothing expected",
                                          verdict, cause));
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (verdict !== want.verdict)
                begin
                    report_mismatch($sformatf("verdict %b, expected %b (cause %b)",
                                              verdict, want.verdict, want.cause));
                end
                if (cause !== want.cause)
                begin
                    report_mismatch($sformatf("cause %b, expected %b", cause, want.cause));
                end
            end
            if (!$isunknown(cause))
            begin
                cause_seen[cause]++;
            end
        end
    end

    // Stimulus.
    initial
    begin
        filter_req_t   r;
        directed_row_t row;
        int            pick;
        int            len;
        logic [15:0]   etype;
        bit            drained_mid;

        drained_mid = 1'b0;
        for (int k = 0; k < TABLE_SIZE; k++)
        begin
            deny_addr[k] = '0;
            deny_len[k] = '0;
            deny_valid[k] = 1'b0;
        end

        // Directed table: size boundaries, protocol checks, prefix extremes.
        directed_rows[0]  = frame_row(1, 16'h0800, 32'h0, 1'b1, VERDICT_PASS, CAUSE_TRUNCATED);
        directed_rows[1]  = frame_row(13, 16'h0800, 32'h0, 1'b1, VERDICT_PASS, CAUSE_TRUNCATED);
        directed_rows[2]  = frame_row(14, 16'h86DD, 32'h0, 1'b1, VERDICT_PASS, CAUSE_NOT_IPV4);
        directed_rows[3]  = frame_row(14, 16'h0800, 32'h0, 1'b1, VERDICT_PASS, CAUSE_TRUNCATED);
        directed_rows[4]  = frame_row(33, 16'h0800, 32'h0, 1'b1, VERDICT_PASS, CAUSE_TRUNCATED);
        directed_rows[5]  = frame_row(34, 16'h0800, 32'h0A00_0001, 1'b1, VERDICT_PASS,
                                      CAUSE_UNLISTED);
        directed_rows[6]  = write_row(10'd0, 32'h0A00_0000, 6'd8, 1'b1);
        directed_rows[7]  = frame_row(34, 16'h0800, 32'h0A12_3456, 1'b0, 1'b0, 2'd0);
        directed_rows[8]  = frame_row(34, 16'h0800, 32'h0B00_0000, 1'b0, 1'b0, 2'd0);
        directed_rows[9]  = write_row(10'd1023, 32'hFFFF_FFFF, 6'd32, 1'b1);
        directed_rows[10] = frame_row(40, 16'h0800, 32'hFFFF_FFFF, 1'b0, 1'b0, 2'd0);
        directed_rows[11] = frame_row(40, 16'h0800, 32'hFFFF_FFFE, 1'b0, 1'b0, 2'd0);
        directed_rows[12] = write_row(10'd5, 32'hC0A8_0000, 6'd63, 1'b1);
        directed_rows[13] = frame_row(34, 16'h0800, 32'hC0A8_0000, 1'b0, 1'b0, 2'd0);
        directed_rows[14] = frame_row(34, 16'h0800, 32'hC0A8_0001, 1'b0, 1'b0, 2'd0);
        directed_rows[15] = write_row(10'd0, 32'h0A00_0000, 6'd8, 1'b0);
        directed_rows[16] = frame_row(34, 16'h0800, 32'h0A00_0001, 1'b0, 1'b0, 2'd0);
        directed_rows[17] = write_row(10'd7, 32'h1234_5678, 6'd0, 1'b1);
        directed_rows[18] = frame_row(70, 16'h0800, 32'h0000_0000, 1'b0, 1'b0, 2'd0);
        directed_rows[19] = write_row(10'd7, 32'h0000_0000, 6'd0, 1'b0);
        directed_rows[20] = frame_row(80, 16'hFFFF, 32'h0, 1'b1, VERDICT_PASS, CAUSE_NOT_IPV4);
        directed_rows[21] = frame_row(20, 16'h0008, 32'h0, 1'b1, VERDICT_PASS, CAUSE_NOT_IPV4);
        directed_rows[22] = frame_row(63, 16'h0800, 32'h0A00_0001, 1'b0, 1'b0, 2'd0);
        directed_rows[23] = frame_row(64, 16'h0800, 32'hC0A8_0000, 1'b0, 1'b0, 2'd0);
        directed_rows[24] = write_row(10'd1023, 32'h0000_0000, 6'd32, 1'b0);
        directed_rows[25] = frame_row(34, 16'h0800, 32'hFFFF_FFFF, 1'b0, 1'b0, 2'd0);

        // Hold reset low at the start; after release the block clears its table on its own.
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE)
            begin
                r.op = OP_WRITE;
                r.data = 8'($urandom);
                r.last = 1'($urandom_range(0, 1));
                r.slot = row.slot;
                r.addr = row.addr;
                r.plen = row.plen;
                r.valid = row.valid;
                send_request(r, 1'b0, '0);
            end
            else
            begin
                send_frame(int'(row.len), row.etype, row.src, 1'b0, row.typed,
                           '{row.verdict, row.cause});
            end
        end
        hold_until_drained();

        // Random part: mostly well-formed IPv4 frames, plus writes and malformed frames.
        while (requests_sent < ITEM_TARGET)
        begin
            if (!drained_mid && requests_sent >= ITEM_TARGET / 2)
            begin
                hold_until_drained();
                drained_mid = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                random_write();
            end
            else if (pick < 80)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(46, 80) : $urandom_range(34, 45);
                send_frame(len, ETHERTYPE_IPV4, pick_source(), 1'b1, 1'b0, '0);
            end
            else if (pick < 88)
            begin
                case ($urandom_range(0, 3))
                    0: etype = 16'h0008;
                    1: etype = 16'h0801;
                    2: etype = 16'h0000;
                    default:
                    begin
                        etype = 16'($urandom);
                        if (etype == ETHERTYPE_IPV4)
                        begin
                            etype = 16'h86DD;
                        end
                    end
                endcase
                send_frame($urandom_range(14, 48), etype, $urandom, 1'b1, 1'b0, '0);
            end
            else if (pick < 94)
            begin
                send_frame($urandom_range(1, 13), 16'($urandom), $urandom, 1'b1, 1'b0, '0);
            end
            else
            begin
                send_frame($urandom_range(14, 33), ETHERTYPE_IPV4, $urandom, 1'b1, 1'b0, '0);
            end
        end

        // Drain, then watch a while longer for stray verdicts.
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("summary: %0d requests (%0d table writes, %0d frames) in %0d cycles",
                 requests_sent, writes_sent, frames_sent, cycle_count);
        $display("summary: causes seen listed=%0d not-ipv4=%0d truncated=%0d unlisted=%0d",
                 cause_seen[0], cause_seen[1], cause_seen[2], cause_seen[3]);
        if (error_count == 0 && pending_verdicts.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("%0d mismatches, %0d verdicts never seen", error_count,
                     pending_verdicts.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule
